[hdl/geometric_countdown_generator_core_defines.svh]
// Assertion macros used by the checker file gcg_checker.sv.
// No dependencies; expects aclk and aresetn in the scope of use.
`ifndef GEOMETRIC_COUNTDOWN_GENERATOR_CORE_DEFINES_SVH
`define GEOMETRIC_COUNTDOWN_GENERATOR_CORE_DEFINES_SVH

// same-cycle implication
`define GCG_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("gcg assertion failed");

// next-cycle implication
`define GCG_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("gcg assertion failed");

`endif

[hdl/gcg_pkg.sv]
// Shared types and constants of the geometric countdown generator.
// No dependencies.
package gcg_pkg;

    localparam logic [34:0] LCG_MUL   = 35'h5DEECE66D;
    localparam logic [47:0] LCG_ADD   = 48'hB;
    localparam logic [30:0] COUNT_MAX = 31'h7FFF_FFFF;
    localparam logic [1:0]  LCG_LAST_CHUNK = 2'd2;  // three 16-bit chunks of the state

    localparam logic CFG_SAMPLING_ENABLE = 1'b0;
    localparam logic CFG_MEAN_SCALE      = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LCG,
        ST_FIX,
        ST_NORM,
        ST_LOG,
        ST_MUL,
        ST_SAT,
        ST_DONE
    } gcg_state_t;

    typedef struct packed {
        logic       take;       // beat accepted this cycle
        logic       lcg_step;
        logic [1:0] lcg_idx;
        logic       fix;
        logic       norm_step;
        logic       log_step;
        logic       mul;
        logic       sat;
        logic       out_load;
    } gcg_cmd_t;

    typedef struct packed {
        logic sampling_enable;
        logic norm_done;
    } gcg_stat_t;

endpackage

[hdl/gcg_ctrl.sv]
// Sequencer of the geometric countdown generator.
// Depends on gcg_pkg.
module gcg_ctrl #(
    parameter int LOG_FRAC_BITS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  logic               m_tready,
    input  gcg_pkg::gcg_stat_t stat,
    output gcg_pkg::gcg_cmd_t  cmd
);

    localparam int CW = $clog2(LOG_FRAC_BITS);

    gcg_pkg::gcg_state_t state_reg, state_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic                valid_reg, valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= gcg_pkg::ST_IDLE;
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            valid_reg <= valid_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        cmd         = '0;
        cmd.lcg_idx = cnt_reg[1:0];
        s_tready    = 1'b0;
        case (state_reg)
            gcg_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.take   = 1'b1;
                    cnt_next   = '0;
                    state_next = stat.sampling_enable ? gcg_pkg::ST_LCG : gcg_pkg::ST_DONE;
                end
            end
            gcg_pkg::ST_LCG: begin
                cmd.lcg_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg[1:0] == gcg_pkg::LCG_LAST_CHUNK) begin
                    state_next = gcg_pkg::ST_FIX;
                end
            end
            gcg_pkg::ST_FIX: begin
                cmd.fix    = 1'b1;
                state_next = gcg_pkg::ST_NORM;
            end
            gcg_pkg::ST_NORM: begin
                cmd.norm_step = 1'b1;
                cnt_next      = '0;
                if (stat.norm_done) begin
                    state_next = gcg_pkg::ST_LOG;
                end
            end
            gcg_pkg::ST_LOG: begin
                cmd.log_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CW'(LOG_FRAC_BITS - 1)) begin
                    state_next = gcg_pkg::ST_MUL;
                end
            end
            gcg_pkg::ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = gcg_pkg::ST_SAT;
            end
            gcg_pkg::ST_SAT: begin
                cmd.sat    = 1'b1;
                state_next = gcg_pkg::ST_DONE;
            end
            gcg_pkg::ST_DONE: begin
                // wait for the output register to drain
                if (!valid_reg || m_tready) begin
                    cmd.out_load = 1'b1;
                    state_next   = gcg_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = gcg_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.out_load) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    assign m_tvalid = valid_reg;

endmodule

[hdl/gcg_datapath.sv]
// Datapath: config registers, generator state, chunked LCG multiply,
// normalize, squaring log2, scale multiply and saturation. Depends on gcg_pkg.
module gcg_datapath #(
    parameter int LOG_FRAC_BITS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic               cfg_addr,
    input  logic [31:0]        cfg_wdata,
    input  logic               mode,
    input  logic [47:0]        seed_value,
    input  gcg_pkg::gcg_cmd_t  cmd,
    output gcg_pkg::gcg_stat_t stat,
    output logic [30:0]        countdown
);

    localparam int F   = LOG_FRAC_BITS;
    localparam int NLW = F + 6;        // negative log2 width
    localparam int PW  = NLW + 32;     // scaled product width
    localparam int QW  = PW - (F + 16);
    localparam logic [NLW-1:0] LOG_BASE = NLW'(48) << F;

    logic        enable_reg;
    logic [31:0] scale_reg;
    logic [47:0] gen_reg;
    logic [47:0] acc_reg, acc_next;
    logic [47:0] norm_reg;
    logic [5:0]  top_reg;
    logic [31:0] z_reg;
    logic [F-1:0] frac_reg;
    logic [PW-1:0] prod_reg;
    logic [30:0] res_reg;
    logic [30:0] out_reg;

    // config and generator state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg <= 1'b0;
            scale_reg  <= '0;
            gen_reg    <= '0;
        end else begin
            if (cfg_wr_en && cfg_addr == gcg_pkg::CFG_SAMPLING_ENABLE) begin
                enable_reg <= cfg_wdata[0];
            end
            if (cfg_wr_en && cfg_addr == gcg_pkg::CFG_MEAN_SCALE) begin
                scale_reg <= cfg_wdata;
            end
            if (cmd.take && mode) begin
                gen_reg <= seed_value;
            end else if (cmd.fix) begin
                gen_reg <= (acc_reg == '0) ? gcg_pkg::LCG_ADD : acc_reg;
            end
        end
    end

    // LCG: 16-bit chunk of the state times the constant, one chunk a cycle
    logic [15:0] chunk;
    logic [50:0] part;
    logic [47:0] part_sh;

    always_comb begin
        case (cmd.lcg_idx)
            2'd0:    chunk = gen_reg[15:0];
            2'd1:    chunk = gen_reg[31:16];
            default: chunk = gen_reg[47:32];
        endcase
        part = 51'(chunk) * 51'(gcg_pkg::LCG_MUL);
        case (cmd.lcg_idx)
            2'd0:    part_sh = part[47:0];
            2'd1:    part_sh = {part[31:0], 16'b0};
            default: part_sh = {part[15:0], 32'b0};
        endcase
        acc_next = acc_reg;
        if (cmd.take) begin
            acc_next = gcg_pkg::LCG_ADD;
        end else if (cmd.lcg_step) begin
            acc_next = acc_reg + part_sh;
        end
    end

    // leading zeros of the top byte
    logic [2:0] lz;
    always_comb begin
        lz = 3'd7;
        for (int i = 0; i < 8; i++) begin
            if (norm_reg[40 + i]) begin
                lz = 3'(7 - i);
            end
        end
    end

    // one squaring per fraction bit
    logic [63:0] sq;
    logic [32:0] sq_t;
    assign sq   = 64'(z_reg) * 64'(z_reg);
    assign sq_t = sq[63:31];

    logic [NLW-1:0] neglog;
    assign neglog = LOG_BASE - {top_reg, frac_reg};

    logic [QW-1:0] q;
    assign q = prod_reg[PW-1:F+16];

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
        if (cmd.fix) begin
            norm_reg <= (acc_reg == '0) ? gcg_pkg::LCG_ADD : acc_reg;
            top_reg  <= 6'd47;
        end else if (cmd.norm_step) begin
            if (norm_reg[47]) begin
                z_reg    <= norm_reg[47:16];
                frac_reg <= '0;
            end else if (norm_reg[47:40] == 8'd0) begin
                norm_reg <= {norm_reg[39:0], 8'd0};
                top_reg  <= top_reg - 6'd8;
            end else begin
                norm_reg <= norm_reg << lz;
                top_reg  <= top_reg - 6'(lz);
            end
        end
        if (cmd.log_step) begin
            z_reg    <= sq_t[32] ? sq_t[32:1] : sq_t[31:0];
            frac_reg <= {frac_reg[F-2:0], sq_t[32]};
        end
        if (cmd.mul) begin
            prod_reg <= PW'(neglog) * PW'(scale_reg);
        end
        if (cmd.take) begin
            res_reg <= gcg_pkg::COUNT_MAX;
        end else if (cmd.sat) begin
            res_reg <= (31'(q) >= gcg_pkg::COUNT_MAX - 31'd1) ? gcg_pkg::COUNT_MAX
                                                              : 31'(q) + 31'd1;
        end
        if (cmd.out_load) begin
            out_reg <= res_reg;
        end
    end

    assign stat.sampling_enable = enable_reg;
    assign stat.norm_done       = norm_reg[47];
    assign countdown            = out_reg;

endmodule

[hdl/geometric_countdown_generator_core.sv]
// Top level of the geometric countdown generator: controller plus datapath.
// Depends on gcg_pkg, gcg_ctrl, gcg_datapath.
//
//  channel  | dir | payload
//  ---------+-----+---------------------------------------------
//  s_       | in  | tuser: mode; tdata: seed_value[47:0]
//  m_       | out | tdata: countdown[30:0], bit 31 zero
//  cfg_     | in  | addr 0 sampling_enable, addr 1 mean_scale
//
// Drawing an item runs a chunked LCG multiply over three 16-bit chunks, then the
// normalize steps, then one squaring per fraction bit, which makes up the bulk of
// the work. With sampling off, an item goes straight to the output stage.
// One item is in work at a time; a finished result waits in the output register
// while the next beat is taken. Reset is synchronous, active low, and clears the
// generator state and both config registers.
module geometric_countdown_generator_core #(
    parameter int LOG_FRAC_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_addr,
    input  logic [31:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,    // [47:0] seed_value
    input  logic        s_tuser,    // [0] mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata     // [30:0] countdown, [31] zero
);

    gcg_pkg::gcg_cmd_t  cmd;
    gcg_pkg::gcg_stat_t stat;
    logic [30:0]        countdown;

    gcg_ctrl #(
        .LOG_FRAC_BITS(LOG_FRAC_BITS)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    gcg_datapath #(
        .LOG_FRAC_BITS(LOG_FRAC_BITS)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .mode       (s_tuser),
        .seed_value (s_tdata),
        .cmd        (cmd),
        .stat       (stat),
        .countdown  (countdown)
    );

    assign m_tdata = {1'b0, countdown};

endmodule

[hdl/gcg_checker.sv]
// Port-level checks of the geometric countdown generator, bound to the top.
// Depends on geometric_countdown_generator_core_defines.svh.
`include "geometric_countdown_generator_core_defines.svh"

module gcg_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    logic [1:0] pending_reg, pending_next;
    logic       s_beat, m_beat;

    assign s_beat = s_tvalid && s_tready;
    assign m_beat = m_tvalid && m_tready;

    always_comb begin
        pending_next = pending_reg + 2'(s_beat) - 2'(m_beat);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= '0;
        end else begin
            pending_reg <= pending_next;
        end
    end

    // stalled result holds
    `GCG_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    // countdown is never zero and the pad bit stays clear
    `GCG_ASSERT_NOW(a_out_range, m_tvalid, m_tdata[30:0] != 31'd0 && !m_tdata[31])
    // one item in work: input closes after each beat
    `GCG_ASSERT_NEXT(a_one_at_a_time, s_beat, !s_tready)
    // every result belongs to an accepted item
    `GCG_ASSERT_NOW(a_no_extra_result, m_beat, pending_reg != 2'd0)

endmodule

bind geometric_countdown_generator_core gcg_checker u_gcg_checker (.*);

[tb/sv/tb_geometric_countdown_generator_core.sv]
// Self-checking bench for geometric_countdown_generator_core: a scoreboard class
// predicts every countdown from the accepted beats and the register settings.
// Depends on gcg_pkg and the core RTL.

class countdown_scoreboard;
    localparam int          FRAC_BITS = 16;
    localparam logic [47:0] LCG_MUL   = 48'h5DEECE66D;
    localparam logic [47:0] LCG_ADD   = 48'hB;
    localparam logic [30:0] COUNT_CAP = 31'h7FFF_FFFF;

    logic [47:0] lcg_state;
    logic        sampling_on;
    logic [31:0] scale_q16;
    logic [30:0] countdown_q[$];
    int          errors;

    function new();
        lcg_state   = '0;
        sampling_on = 1'b0;
        scale_q16   = '0;
        errors      = 0;
    endfunction

    function void write_reg(logic addr, logic [31:0] value);
        if (addr == gcg_pkg::CFG_SAMPLING_ENABLE)
            sampling_on = value[0];
        else
            scale_q16 = value;
    endfunction

    static function logic [47:0] lcg_advance(logic [47:0] x);
        return LCG_MUL * x + LCG_ADD;
    endfunction

    // seed whose successor is the given state (inverse of the odd multiplier mod 2^48)
    static function logic [47:0] seed_leading_to(logic [47:0] target);
        logic [47:0] inv;
        inv = LCG_MUL;
        repeat (6) inv = inv * (48'd2 - LCG_MUL * inv);
        return (target - LCG_ADD) * inv;
    endfunction

    // -log2(x / 2^48) with FRAC_BITS fraction bits, by repeated squaring
    static function logic [63:0] neg_log2(logic [47:0] x);
        int               top;
        logic [63:0]      z;
        logic [FRAC_BITS-1:0] frac;
        top  = 47;
        frac = '0;
        while (x[top] == 1'b0 && top > 0)
            top--;
        z = ({16'b0, x} << (47 - top)) >> 16;
        for (int i = 0; i < FRAC_BITS; i++) begin
            z = (z * z) >> 31;
            frac = {frac[FRAC_BITS-2:0], z[32]};
            if (z[32])
                z = z >> 1;
        end
        return (64'd48 << FRAC_BITS) - ((64'(top) << FRAC_BITS) | 64'(frac));
    endfunction

    function void note_input(logic mode, logic [47:0] seed);
        logic [47:0] x;
        logic [63:0] q;
        if (mode)
            lcg_state = seed;
        if (!sampling_on) begin
            countdown_q.push_back(COUNT_CAP);
            return;
        end
        x = lcg_advance(lcg_state);
        if (x == '0)
            x = lcg_advance(x);
        lcg_state = x;
        q = (neg_log2(x) * 64'(scale_q16)) >> (FRAC_BITS + 16);
        if (q >= 64'(COUNT_CAP) - 64'd1)
            countdown_q.push_back(COUNT_CAP);
        else
            countdown_q.push_back(31'(q + 64'd1));
    endfunction

    function void check_result(logic [31:0] data);
        logic [30:0] want;
        if (countdown_q.size() == 0) begin
            $display("%0t: unexpected countdown beat, actual %h", $time, data);
            errors++;
            return;
        end
        want = countdown_q.pop_front();
        if (data !== {1'b0, want}) begin
            $display("%0t: countdown mismatch, expected %h actual %h", $time, {1'b0, want}, data);
            errors++;
        end
    endfunction

    function int pending();
        return countdown_q.size();
    endfunction
endclass

module tb_geometric_countdown_generator_core;

    localparam int   LOG_FRAC_BITS = 16;
    localparam logic MODE_DRAW   = 1'b0;
    localparam logic MODE_RESEED = 1'b1;
    localparam int   STALL_LIMIT = 4000;
    localparam int   PHASE_BEATS = 130;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic        cfg_addr  = 1'b0;
    logic [31:0] cfg_wdata = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata   = '0;
    logic        s_tuser   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;

    logic        steady = 1'b0;   // no idling on either side while set
    int unsigned stall_cycles = 0;

    countdown_scoreboard sb = new();

    geometric_countdown_generator_core #(
        .LOG_FRAC_BITS(LOG_FRAC_BITS)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_addr(cfg_addr),
        .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata)
    );

    always #6 aclk = ~aclk;

    always @(posedge aclk) begin
        if (!aresetn)
            m_tready <= 1'b0;
        else
            m_tready <= steady || ($urandom_range(0, 99) >= 20);
    end

    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready)
            sb.note_input(s_tuser, s_tdata);
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata);
    end

    always @(posedge aclk) begin
        if (!aresetn || cfg_wr_en || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic send_beat(input logic mode, input logic [47:0] seed);
        int gap;
        if (!steady && $urandom_range(0, 99) < 25) begin
            gap = $urandom_range(1, 50);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= seed;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic send_random_beat();
        logic        mode;
        logic [47:0] seed;
        seed = {16'($urandom), $urandom};
        mode = ($urandom_range(0, 99) < 15) ? MODE_RESEED : MODE_DRAW;
        if (mode == MODE_RESEED) begin
            case ($urandom_range(0, 19))
                0: seed = sb.seed_leading_to('0);
                1: seed = '0;
                2: seed = '1;
                3: seed = sb.seed_leading_to(48'd1);
                default: ;
            endcase
        end
        send_beat(mode, seed);
    endtask

    // all countdowns back means the core has nothing in work
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        @(posedge aclk);
    endtask

    task automatic program_regs(input logic enable, input logic [31:0] scale);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= gcg_pkg::CFG_SAMPLING_ENABLE;
        cfg_wdata <= {31'b0, enable};
        @(posedge aclk);
        sb.write_reg(gcg_pkg::CFG_SAMPLING_ENABLE, {31'b0, enable});
        cfg_addr  <= gcg_pkg::CFG_MEAN_SCALE;
        cfg_wdata <= scale;
        @(posedge aclk);
        sb.write_reg(gcg_pkg::CFG_MEAN_SCALE, scale);
        cfg_wr_en <= 1'b0;
    endtask

    initial begin
        logic        enable;
        logic [31:0] scale;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // reset settings: sampling off, seeds still load
        send_beat(MODE_DRAW, '0);
        send_beat(MODE_RESEED, '1);
        send_beat(MODE_DRAW, 48'h1234_5678_9ABC);
        send_beat(MODE_RESEED, 48'h0000_0000_0001);
        wait_idle();

        // zero scale: every draw is 1, first draw continues from the seed loaded above
        program_regs(1'b1, 32'h0);
        send_beat(MODE_DRAW, '1);
        send_beat(MODE_DRAW, '0);
        wait_idle();

        program_regs(1'b1, 32'hFFFF_FFFF);
        send_beat(MODE_RESEED, sb.seed_leading_to('0));   // zero-state skip
        send_beat(MODE_RESEED, sb.seed_leading_to(48'd1)); // deepest log
        send_beat(MODE_RESEED, sb.seed_leading_to('1));    // shallowest log
        send_beat(MODE_RESEED, '0);
        send_beat(MODE_DRAW, 48'h0);
        send_beat(MODE_RESEED, 48'h5555_5555_5555);
        send_beat(MODE_RESEED, 48'hAAAA_AAAA_AAAA);
        send_beat(MODE_DRAW, '1);
        wait_idle();

        program_regs(1'b1, 32'h0001_0000);
        send_beat(MODE_RESEED, 48'h8000_0000_0000);
        send_beat(MODE_DRAW, 48'h0);
        send_beat(MODE_RESEED, sb.seed_leading_to(48'h8000_0000_0000));
        send_beat(MODE_DRAW, 48'h0);
        wait_idle();

        for (int ph = 0; ph < 10; ph++) begin
            enable = (ph == 1) ? 1'b0 : ($urandom_range(0, 5) != 0);
            case (ph == 0 ? 0 : $urandom_range(0, 5))
                0: scale = 32'hFFFF_FFFF;
                1: scale = 32'h0;
                2: scale = 32'h1;
                3: scale = $urandom_range(0, 32'h00FF_FFFF);
                default: scale = $urandom;
            endcase
            program_regs(enable, scale);
            steady = (ph == 4 || ph == 5);
            for (int n = 0; n < PHASE_BEATS; n++)
                send_random_beat();
            wait_idle();
        end
        steady = 1'b0;

        repeat (40) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
